/* rtl/core/chorus_pkg.sv */
`default_nettype none
package chorus_pkg;

	localparam int unsigned DELAY_DEPTH_DEF = 4096;
	localparam int unsigned SINE_SIZE_DEF   = 1024;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MODE_ON    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LFO_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL  = 3'd4;

	localparam logic [19:0] BASE_DELAY_RST = 20'd86016;
	localparam logic [19:0] MOD_DEPTH_RST  = 20'd24576;
	localparam logic [23:0] LFO_STEP_RST   = 24'd175;
	localparam logic [15:0] WET_LEVEL_RST  = 16'd16384;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_WR, ST_MOD, ST_DLY,
		ST_RA, ST_RB, ST_RC, ST_RD, ST_RE, ST_RF
	} state_t;

	// Q30 polynomial sine, evaluated at elaboration only
	function automatic logic signed [15:0] sine_entry(input int unsigned k,
		input int unsigned lg);
		longint unsigned u, t, t2, a, s, q;
		logic [1:0] quad;
		u = longint'(k) << (32 - lg);
		quad = u[31:30];
		t = u & 64'h3FFF_FFFF;
		if (quad[0])
			t = 64'h4000_0000 - t;
		t2 = (t * t) >> 30;
		a = 64'd172272;
		a = 64'd5026996 - ((t2 * a) >> 30);
		a = 64'd85569306 - ((t2 * a) >> 30);
		a = 64'd693598668 - ((t2 * a) >> 30);
		a = 64'd1686629713 - ((t2 * a) >> 30);
		s = (t * a) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767)
			q = 64'd32767;
		return quad[1] ? -$signed(q[15:0]) : $signed(q[15:0]);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/chorus_if.sv */
`default_nettype none
interface chorus_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface chorus_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/chorus_sine_rom.sv */
`default_nettype none
module chorus_sine_rom #(
	parameter int unsigned SINE_TABLE_SIZE = chorus_pkg::SINE_SIZE_DEF
) (
	input  wire logic                               clk,
	input  wire logic [$clog2(SINE_TABLE_SIZE)-1:0] addr,
	output logic signed [15:0]                      data
);
	import chorus_pkg::*;

	localparam int unsigned SW = $clog2(SINE_TABLE_SIZE);

	logic signed [15:0] rom [SINE_TABLE_SIZE];

	for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_rom
		assign rom[k] = sine_entry(k, SW);
	end

	always_ff @(posedge clk) begin
		data <= rom[addr];
	end
endmodule
`default_nettype wire

/* rtl/core/stereo_chorus_lfo_delay.sv */
`default_nettype none
// Stereo chorus: one mono sample in, one left/right pair out.
// In bypass the sample is registered straight to both outputs. A new sample is
// taken only in idle once the previous pair has been handed over, in either mode;
// a single shared multiplier under the sequencer does every product in turn.
// Reset: asynchronous, active low; the delay line is then cleared one entry a
// cycle, and no sample is taken until the clear is done.
module stereo_chorus_lfo_delay #(
	parameter int unsigned DELAY_DEPTH     = chorus_pkg::DELAY_DEPTH_DEF,
	parameter int unsigned SINE_TABLE_SIZE = chorus_pkg::SINE_SIZE_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [chorus_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [chorus_pkg::CFG_DATA_W-1:0]     cfg_data,
	chorus_in_if.sink                                  din,
	chorus_out_if.source                               dout
);
	import chorus_pkg::*;

	localparam int unsigned AW = $clog2(DELAY_DEPTH);
	localparam int unsigned SW = $clog2(SINE_TABLE_SIZE);
	localparam int unsigned PW = AW + 8;
	localparam logic signed [25:0] DLY_MAX = 26'((DELAY_DEPTH - 1) * 256);
	localparam logic signed [25:0] DLY_MIN = 26'sd256;

	// configuration
	logic        mode_q;
	logic [19:0] base_q, depth_q;
	logic [23:0] step_q;
	logic [15:0] wet_lvl_q;

	// control
	state_t      st_q, st_d;
	logic        side_q;
	logic [AW-1:0] clr_q, wp_q;
	logic [23:0] phase_q;
	logic        out_v_q;

	// datapath
	logic signed [15:0] x_q, left_q, right_q, rd_q, sin_d;
	logic signed [24:0] wet_q;
	logic signed [41:0] dry_q;
	logic signed [45:0] prod_q;
	logic [PW-1:0]      posl_q, posr_q;

	logic signed [24:0] mul_a;
	logic signed [20:0] mul_b;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic signed [15:0] mem_wdata;
	logic [PW-1:0]      pos_sel;
	logic [7:0]         frac;
	logic signed [16:0] dry_gain;
	logic signed [21:0] m_val;
	logic signed [25:0] dl_raw, dr_raw, dl, dr;
	logic signed [45:0] acc;
	logic signed [22:0] rnd;
	logic signed [15:0] sat;
	logic               take;

	logic signed [15:0] mem [DELAY_DEPTH];

	chorus_sine_rom #(.SINE_TABLE_SIZE(SINE_TABLE_SIZE)) u_sine (
		.clk  (clk),
		.addr (phase_q[23 -: SW]),
		.data (sin_d)
	);

	assign din.ready      = (st_q == ST_IDLE) && !out_v_q;
	assign take           = din.valid && din.ready;
	assign dout.valid     = out_v_q;
	assign dout.left_out  = left_q;
	assign dout.right_out = right_q;

	assign pos_sel  = side_q ? posr_q : posl_q;
	assign frac     = pos_sel[7:0];
	assign dry_gain = 17'sd32768 - $signed({2'b00, wet_lvl_q[15:1]});

	// modulation offset and clamped delays, rounding halves upward
	assign m_val  = 22'((prod_q + 46'sd16384) >>> 15);
	assign dl_raw = $signed({6'd0, base_q}) + 26'(m_val);
	assign dr_raw = $signed({6'd0, base_q}) - 26'(m_val);
	assign dl = (dl_raw > DLY_MAX) ? DLY_MAX : (dl_raw < DLY_MIN) ? DLY_MIN : dl_raw;
	assign dr = (dr_raw > DLY_MAX) ? DLY_MAX : (dr_raw < DLY_MIN) ? DLY_MIN : dr_raw;

	// final mix: round by 2^23 and saturate
	assign acc = 46'(dry_q) + prod_q;
	assign rnd = 23'((acc + 46'sd4194304) >>> 23);
	assign sat = (rnd > 23'sd32767) ? 16'sh7FFF :
		(rnd < -23'sd32768) ? 16'sh8000 : rnd[15:0];

	// sequencer: next state, multiplier operands, memory ports
	always_comb begin
		st_d      = st_q;
		mul_a     = '0;
		mul_b     = '0;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = x_q;
		mem_raddr = pos_sel[PW-1:8];
		case (st_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DELAY_DEPTH - 1))
					st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take && mode_q)
					st_d = ST_WR;
			end
			ST_WR: begin
				mem_we = 1'b1;
				mul_a  = 25'(x_q);
				mul_b  = 21'(dry_gain);
				st_d   = ST_MOD;
			end
			ST_MOD: begin
				mul_a = 25'(sin_d);
				mul_b = $signed({1'b0, depth_q});
				st_d  = ST_DLY;
			end
			ST_DLY: st_d = ST_RA;
			ST_RA:  st_d = ST_RB;
			ST_RB: begin
				mem_raddr = pos_sel[PW-1:8] + AW'(1);
				mul_a     = 25'(rd_q);
				mul_b     = $signed({12'd0, 9'(9'd256 - {1'b0, frac})});
				st_d      = ST_RC;
			end
			ST_RC: begin
				mul_a = 25'(rd_q);
				mul_b = $signed({13'd0, frac});
				st_d  = ST_RD;
			end
			ST_RD: st_d = ST_RE;
			ST_RE: begin
				mul_a = wet_q;
				mul_b = $signed({5'd0, wet_lvl_q});
				st_d  = ST_RF;
			end
			ST_RF: st_d = side_q ? ST_IDLE : ST_RA;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLR;
			clr_q     <= '0;
			side_q    <= 1'b0;
			wp_q      <= '0;
			phase_q   <= '0;
			out_v_q   <= 1'b0;
			mode_q    <= 1'b0;
			base_q    <= BASE_DELAY_RST;
			depth_q   <= MOD_DEPTH_RST;
			step_q    <= LFO_STEP_RST;
			wet_lvl_q <= WET_LEVEL_RST;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR)
				clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				case (cfg_idx)
					REG_MODE_ON:    mode_q    <= cfg_data[0];
					REG_BASE_DELAY: base_q    <= cfg_data[19:0];
					REG_MOD_DEPTH:  depth_q   <= cfg_data[19:0];
					REG_LFO_STEP:   step_q    <= cfg_data[23:0];
					REG_WET_LEVEL:  wet_lvl_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (dout.valid && dout.ready)
				out_v_q <= 1'b0;
			// bypass: pass the sample straight to both sides
			if (take && !mode_q)
				out_v_q <= 1'b1;
			if (st_q == ST_RF) begin
				side_q <= !side_q;
				if (side_q) begin
					out_v_q <= 1'b1;
					wp_q    <= wp_q + AW'(1);
					phase_q <= phase_q + step_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= 46'(mul_a * mul_b);
		if (take) begin
			x_q <= din.sample_in;
			if (!mode_q) begin
				left_q  <= din.sample_in;
				right_q <= din.sample_in;
			end
		end
		case (st_q)
			ST_MOD: dry_q <= 42'(prod_q) <<< 8;
			ST_DLY: begin
				posl_q <= {wp_q, 8'd0} - dl[PW-1:0];
				posr_q <= {wp_q, 8'd0} - dr[PW-1:0];
			end
			ST_RC: wet_q <= prod_q[24:0];
			ST_RD: wet_q <= wet_q + prod_q[24:0];
			ST_RF: begin
				if (side_q)
					right_q <= sat;
				else
					left_q <= sat;
			end
			default: ;
		endcase
	end

	// delay line: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_q <= mem[mem_raddr];
	end
endmodule
`default_nettype wire
